// ----- rtl/core/mpaf_pkg.sv -----
// Package for the mesh packet admission filter: item function codes, drop reasons,
// counter numbering and rule reset values. No dependencies.
package mpaf_pkg;

  typedef enum logic [2:0] {
    FUNC_CHECK  = 3'd0,
    FUNC_RULE   = 3'd1,
    FUNC_SLOT   = 3'd2,
    FUNC_READ   = 3'd3,
    FUNC_CLEAR  = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    RSN_PASS      = 3'd0,
    RSN_TYPE      = 3'd1,
    RSN_HOPS      = 3'd2,
    RSN_RATE      = 3'd3,
    RSN_HASH      = 3'd4,
    RSN_CHANNEL   = 3'd5,
    RSN_MALFORMED = 3'd6
  } reason_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EXEC  = 2'd1,
    ST_CLEAR = 2'd2
  } state_e;

  localparam logic [1:0] CFG_FILTER_EN = 2'd0;
  localparam logic [1:0] CFG_MIN_HASH  = 2'd1;
  localparam logic [1:0] CFG_MALFORMED = 2'd2;

  localparam int unsigned GROUP_TEXT_TYPE = 5;
  localparam int unsigned REASON_COUNT    = 6;
  localparam int unsigned CNT_REASON_BASE = 2;
  localparam int unsigned CNT_TYPE_BASE   = 8;
  localparam logic [9:0]  MS_PER_S        = 10'd1000;

  // Rule fields held per packet type.
  typedef struct packed {
    logic        enabled;
    logic [5:0]  max_hops;
    logic [15:0] limit;
    logic [11:0] window_s;
  } rule_t;

  // Rate window state per packet type.
  typedef struct packed {
    logic        open;
    logic [31:0] start_ms;
    logic [15:0] count;
  } window_t;

  function automatic rule_t rule_reset(input int unsigned t);
    rule_t r;
    r.enabled  = 1'b1;
    r.max_hops = (t == 5) ? 6'd32 : 6'd8;
    r.limit    = (t == 2 || t == 5) ? 16'd20 : ((t == 4) ? 16'd10 : 16'd5);
    r.window_s = 12'd60;
    return r;
  endfunction

endpackage

// ----- rtl/core/mpaf_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module mpaf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [$clog2((Depth > 1) ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic [$clog2((Depth > 1) ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/mesh_packet_admission_filter.sv -----
// Mesh packet admission filter top level: decision logic, rule and counter stores.
// Depends on mpaf_pkg and mpaf_ram.
//
// One item is taken when start_i is high and busy_o is low. For each item, the
// accept cycle reads the type's rule, window and drop counter from the
// memories; the execute state then decides, writes back and registers the
// result, driven for one cycle on done_o. The receiver cannot stall. After
// reset the block runs a clearing pass over all TYPE_COUNT types that loads
// rule defaults and zeroes windows and per-type counters; busy_o stays high
// meanwhile. Func 4 (clear counters) zeroes the totals and runs a like pass
// over the per-type drop counters. Configuration writes are taken at any cycle.
module mesh_packet_admission_filter
  import mpaf_pkg::*;
#(
  parameter int unsigned TYPE_COUNT    = 12,
  parameter int unsigned CHANNEL_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  func_i,
  input  logic [4:0]  entry_index_i,
  input  logic [7:0]  hop_count_i,
  input  logic [1:0]  path_hash_bytes_i,
  input  logic [7:0]  payload_length_i,
  input  logic [7:0]  lead_byte_i,
  input  logic        exempt_flag_i,
  input  logic [31:0] now_ms_i,
  input  logic        rule_on_i,
  input  logic [5:0]  rule_hops_i,
  input  logic [15:0] rule_limit_i,
  input  logic [11:0] rule_window_s_i,
  output logic        done_o,
  output logic        forward_o,
  output logic [2:0]  drop_reason_o,
  output logic [31:0] counter_value_o
);

  localparam int unsigned TW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
  localparam int unsigned SW = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;
  localparam int unsigned RuleW = $bits(rule_t);
  localparam int unsigned WinW  = $bits(window_t);

  // configuration registers
  logic       filter_en_q, malformed_q;
  logic [1:0] min_hash_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_en_q <= 1'b0;
      min_hash_q  <= 2'd1;
      malformed_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FILTER_EN: filter_en_q <= cfg_wdata_i[0];
        CFG_MIN_HASH:  min_hash_q  <= cfg_wdata_i;
        CFG_MALFORMED: malformed_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [2:0]  func_q;
  logic [4:0]  idx_q;
  logic [7:0]  hops_q, len_q, lead_q;
  logic [1:0]  hsize_q;
  logic        exempt_q, on_q;
  logic [31:0] now_q;
  logic [5:0]  rhops_q;
  logic [15:0] rlimit_q;
  logic [11:0] rwin_q;

  state_e      state_q, state_d;
  logic [TW-1:0] sweep_q, sweep_d;
  logic        init_q, init_d;

  // small register stores
  logic [7:0]  ch_hash_q [CHANNEL_SLOTS];
  logic [CHANNEL_SLOTS-1:0] ch_valid_q;
  logic [31:0] by_reason_q [REASON_COUNT];
  logic [31:0] passed_q, exempt_cnt_q;

  // memories
  logic          mem_we, cnt_we;
  logic [TW-1:0] waddr, raddr, cnt_waddr;
  rule_t         rule_wd, rule_rd;
  window_t       win_wd, win_rd;
  logic [31:0]   cnt_wd, cnt_rd;

  mpaf_ram #(.Width(RuleW), .Depth(TYPE_COUNT)) u_rule_ram (
    .clk_i, .we_i(mem_we), .waddr_i(waddr), .wdata_i(rule_wd),
    .raddr_i(raddr), .rdata_o(rule_rd)
  );
  mpaf_ram #(.Width(WinW), .Depth(TYPE_COUNT)) u_win_ram (
    .clk_i, .we_i(mem_we), .waddr_i(waddr), .wdata_i(win_wd),
    .raddr_i(raddr), .rdata_o(win_rd)
  );
  mpaf_ram #(.Width(32), .Depth(TYPE_COUNT)) u_cnt_ram (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wd),
    .raddr_i(raddr), .rdata_o(cnt_rd)
  );

  logic accept;
  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // read address: type for packets, counter number minus base for reads
  logic [4:0] cnt_off;
  assign cnt_off = entry_index_i - 5'(CNT_TYPE_BASE);
  assign raddr = (func_i == FUNC_READ) ? cnt_off[TW-1:0] : entry_index_i[TW-1:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= func_i;
      idx_q    <= entry_index_i;
      hops_q   <= hop_count_i;
      hsize_q  <= path_hash_bytes_i;
      len_q    <= payload_length_i;
      lead_q   <= lead_byte_i;
      exempt_q <= exempt_flag_i;
      now_q    <= now_ms_i;
      on_q     <= rule_on_i;
      rhops_q  <= rule_hops_i;
      rlimit_q <= rule_limit_i;
      rwin_q   <= rule_window_s_i;
    end
  end

  // decision datapath (execute cycle)
  logic        type_ok, chan_hit, bad_len, rate_on, expired, rate_ok;
  logic [21:0] span;
  logic [31:0] elapsed;
  logic [2:0]  reason;
  logic [15:0] cnt_base;
  logic [7:0]  len_m3;

  assign type_ok = (idx_q < 5'(TYPE_COUNT));
  assign len_m3  = len_q - 8'd3;
  assign bad_len = (len_q < 8'd19) || (len_m3[3:0] != 4'd0);

  always_comb begin
    chan_hit = 1'b0;
    for (int i = 0; i < CHANNEL_SLOTS; i++) begin
      if (ch_valid_q[i] && ch_hash_q[i] == lead_q) chan_hit = 1'b1;
    end
  end

  assign span    = 22'(rule_rd.window_s) * 22'(MS_PER_S);
  assign elapsed = now_q - win_rd.start_ms;
  assign rate_on = (rule_rd.limit != 16'd0) && (rule_rd.window_s != 12'd0);
  assign expired = !win_rd.open || (elapsed >= 32'(span));
  assign cnt_base = expired ? 16'd0 : win_rd.count;
  assign rate_ok  = !rate_on || (cnt_base < rule_rd.limit);

  always_comb begin
    if (!rule_rd.enabled) begin
      reason = RSN_TYPE;
    end else if (rule_rd.max_hops == 6'd0 || hops_q >= 8'(rule_rd.max_hops)) begin
      reason = RSN_HOPS;
    end else if (hsize_q < min_hash_q) begin
      reason = RSN_HASH;
    end else if (idx_q == 5'(GROUP_TEXT_TYPE) && malformed_q && bad_len) begin
      reason = RSN_MALFORMED;
    end else if (idx_q == 5'(GROUP_TEXT_TYPE) && len_q != 8'd0 && chan_hit) begin
      reason = RSN_CHANNEL;
    end else if (!rate_ok) begin
      reason = RSN_RATE;
    end else begin
      reason = RSN_PASS;
    end
  end

  logic is_pkt;  // counted packet: filter on, type in range, not exempt
  assign is_pkt = filter_en_q && type_ok && !exempt_q;

  // next state and memory writes
  always_comb begin
    state_d   = state_q;
    sweep_d   = sweep_q;
    init_d    = init_q;
    mem_we    = 1'b0;
    cnt_we    = 1'b0;
    waddr     = idx_q[TW-1:0];
    cnt_waddr = idx_q[TW-1:0];
    rule_wd   = rule_rd;
    win_wd    = win_rd;
    cnt_wd    = cnt_rd + 32'd1;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        case (func_q)
          FUNC_CHECK: begin
            if (is_pkt) begin
              if (reason == RSN_PASS && rate_on) begin
                mem_we = 1'b1;
                win_wd.open     = 1'b1;
                win_wd.start_ms = expired ? now_q : win_rd.start_ms;
                win_wd.count    = cnt_base + 16'd1;
              end else if (reason == RSN_RATE && expired) begin
                mem_we = 1'b1;
                win_wd.open     = 1'b1;
                win_wd.start_ms = now_q;
                win_wd.count    = 16'd0;
              end
              cnt_we = (reason != RSN_PASS);
            end
          end
          FUNC_RULE: begin
            if (type_ok) begin
              mem_we = 1'b1;
              rule_wd.enabled  = on_q;
              rule_wd.max_hops = rhops_q;
              rule_wd.limit    = rlimit_q;
              rule_wd.window_s = rwin_q;
              win_wd = '0;
            end
          end
          FUNC_CLEAR: begin
            state_d = ST_CLEAR;
            sweep_d = '0;
          end
          default: ;
        endcase
      end
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = sweep_q;
        cnt_wd    = '0;
        if (init_q) begin
          mem_we  = 1'b1;
          waddr   = sweep_q;
          rule_wd = rule_reset(32'(sweep_q));
          win_wd  = '0;
        end
        if (sweep_q == TW'(TYPE_COUNT - 1)) begin
          state_d = ST_IDLE;
          init_d  = 1'b0;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      sweep_q <= '0;
      init_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      init_q  <= init_d;
    end
  end

  // register stores and totals
  logic exec;
  assign exec = (state_q == ST_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_valid_q   <= '0;
      passed_q     <= '0;
      exempt_cnt_q <= '0;
      for (int i = 0; i < REASON_COUNT; i++) by_reason_q[i] <= '0;
      for (int i = 0; i < CHANNEL_SLOTS; i++) ch_hash_q[i] <= '0;
    end else if (exec) begin
      case (func_q)
        FUNC_CHECK: begin
          if (filter_en_q && type_ok && exempt_q) exempt_cnt_q <= exempt_cnt_q + 32'd1;
          if (is_pkt) begin
            if (reason == RSN_PASS) begin
              passed_q <= passed_q + 32'd1;
            end else begin
              by_reason_q[reason - 3'd1] <= by_reason_q[reason - 3'd1] + 32'd1;
            end
          end
        end
        FUNC_SLOT: begin
          if ({1'b0, idx_q} < 6'(CHANNEL_SLOTS)) begin
            ch_hash_q[idx_q[SW-1:0]]  <= lead_q;
            ch_valid_q[idx_q[SW-1:0]] <= on_q;
          end
        end
        FUNC_CLEAR: begin
          passed_q     <= '0;
          exempt_cnt_q <= '0;
          for (int i = 0; i < REASON_COUNT; i++) by_reason_q[i] <= '0;
        end
        default: ;
      endcase
    end
  end

  // counter read mux
  logic [31:0] read_val;
  always_comb begin
    if (idx_q == 5'd0) begin
      read_val = passed_q;
    end else if (idx_q == 5'd1) begin
      read_val = exempt_cnt_q;
    end else if (idx_q < 5'(CNT_TYPE_BASE)) begin
      read_val = by_reason_q[3'(idx_q - 5'(CNT_REASON_BASE))];
    end else if (idx_q < 5'(CNT_TYPE_BASE + TYPE_COUNT)) begin
      read_val = cnt_rd;
    end else begin
      read_val = '0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      forward_o       <= 1'b0;
      drop_reason_o   <= RSN_PASS;
      counter_value_o <= '0;
      case (func_q)
        FUNC_CHECK: begin
          forward_o     <= !is_pkt || (reason == RSN_PASS);
          drop_reason_o <= is_pkt ? reason : RSN_PASS;
        end
        FUNC_READ: counter_value_o <= read_val;
        default: ;
      endcase
    end
  end

endmodule
